FILE: sv/cbad_pkg.sv
// ============================================================================
// cbad_pkg: shared types and constants of the console bus address decoder
// Holds the command and result item layouts, region codes, fold widths and
// the page map of the console memory.
// ============================================================================
package cbad_pkg;

  // Fold widths of the mirrored regions.
  localparam int WORK_RAM_ADDR_BITS = 21;
  localparam int BIOS_ADDR_BITS     = 19;

  localparam logic [31:0] RAM_MASK  = 32'((64'd1 << WORK_RAM_ADDR_BITS) - 64'd1);
  localparam logic [31:0] BIOS_MASK = 32'((64'd1 << BIOS_ADDR_BITS) - 64'd1);

  // Access kinds.
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Region codes.
  localparam logic [2:0] REGION_WORK     = 3'd0;
  localparam logic [2:0] REGION_LOCAL    = 3'd1;
  localparam logic [2:0] REGION_HWPORT   = 3'd2;
  localparam logic [2:0] REGION_BIOS     = 3'd3;
  localparam logic [2:0] REGION_PARALLEL = 3'd4;
  localparam logic [2:0] REGION_UNMAPPED = 3'd5;
  localparam logic [2:0] REGION_CACHECTL = 3'd6;

  // Page map (page = address bits 31:16).
  localparam logic [15:0] PAGE_RAM_BASE0  = 16'h0000;
  localparam logic [15:0] PAGE_RAM_BASE1  = 16'h8000;
  localparam logic [15:0] PAGE_RAM_BASE2  = 16'hA000;
  localparam logic [15:0] PAGE_RAM_COUNT  = 16'h0080;
  localparam logic [15:0] PAGE_BIOS_BASE0 = 16'h1FC0;
  localparam logic [15:0] PAGE_BIOS_BASE1 = 16'h9FC0;
  localparam logic [15:0] PAGE_BIOS_BASE2 = 16'hBFC0;
  localparam logic [15:0] PAGE_BIOS_COUNT = 16'h0008;
  localparam logic [15:0] PAGE_PARALLEL   = 16'h1F00;
  localparam logic [15:0] PAGE_LOCAL      = 16'h1F80;
  localparam logic [15:0] LOCAL_LIMIT     = 16'h1000;

  // Cache control register and its data codes.
  localparam logic [31:0] CACHE_CTL_ADDR   = 32'hFFFE0130;
  localparam logic [20:0] CACHE_CTL_OFFSET = 21'h000130;
  localparam logic [31:0] ISO_ON_A         = 32'h00000800;
  localparam logic [31:0] ISO_ON_B         = 32'h00000804;
  localparam logic [31:0] ISO_OFF_A        = 32'h00000000;
  localparam logic [31:0] ISO_OFF_B        = 32'h0001E988;

  typedef struct packed {
    logic        command;
    logic [31:0] address;
    logic [31:0] write_data;
  } cbad_cmd_t;

  typedef struct packed {
    logic [2:0]  region;
    logic [20:0] local_offset;
    logic        store_enable;
    logic        read_zero;
    logic        icache_invalidate;
    logic        code_clear;
    logic [29:0] clear_word_address;
    logic        isolated_now;
  } cbad_res_t;

endpackage

FILE: sv/cbad_decode.sv
// ============================================================================
// cbad_decode: single-pass address decode
// Maps one registered bus access to its region, folded offset and write
// qualifiers, and computes the next cache isolation flag.
// ============================================================================
module cbad_decode
  import cbad_pkg::*;
(
  input  cbad_cmd_t cmd,
  input  logic      isolated,
  output cbad_res_t res,
  output logic      isolated_next
);

  logic [15:0] page;
  logic        is_write;
  logic        in_ram;
  logic        in_bios;

  assign page     = cmd.address[31:16];
  assign is_write = (cmd.command == CMD_WRITE);

  assign in_ram =
      (page >= PAGE_RAM_BASE0 && page < PAGE_RAM_BASE0 + PAGE_RAM_COUNT) ||
      (page >= PAGE_RAM_BASE1 && page < PAGE_RAM_BASE1 + PAGE_RAM_COUNT) ||
      (page >= PAGE_RAM_BASE2 && page < PAGE_RAM_BASE2 + PAGE_RAM_COUNT);

  assign in_bios =
      (page >= PAGE_BIOS_BASE0 && page < PAGE_BIOS_BASE0 + PAGE_BIOS_COUNT) ||
      (page >= PAGE_BIOS_BASE1 && page < PAGE_BIOS_BASE1 + PAGE_BIOS_COUNT) ||
      (page >= PAGE_BIOS_BASE2 && page < PAGE_BIOS_BASE2 + PAGE_BIOS_COUNT);

  always_comb begin
    res.region             = REGION_UNMAPPED;
    res.local_offset       = '0;
    res.store_enable       = 1'b0;
    res.read_zero          = 1'b0;
    res.icache_invalidate  = 1'b0;
    res.code_clear         = 1'b0;
    res.clear_word_address = '0;
    isolated_next          = isolated;

    if (page == PAGE_LOCAL) begin
      res.region       = (cmd.address[15:0] < LOCAL_LIMIT) ? REGION_LOCAL : REGION_HWPORT;
      res.local_offset = {5'd0, cmd.address[15:0]};
      res.store_enable = is_write;
    end else if (is_write && cmd.address == CACHE_CTL_ADDR) begin
      res.region       = REGION_CACHECTL;
      res.local_offset = CACHE_CTL_OFFSET;
      if ((cmd.write_data == ISO_ON_A || cmd.write_data == ISO_ON_B) && !isolated) begin
        isolated_next         = 1'b1;
        res.icache_invalidate = 1'b1;
      end else if ((cmd.write_data == ISO_OFF_A || cmd.write_data == ISO_OFF_B) &&
                   isolated) begin
        isolated_next = 1'b0;
      end
    end else begin
      if (in_ram) begin
        res.region       = REGION_WORK;
        res.local_offset = 21'(cmd.address & RAM_MASK);
        res.store_enable = is_write && !isolated;
      end else if (page == PAGE_PARALLEL) begin
        res.region       = REGION_PARALLEL;
        res.local_offset = {5'd0, cmd.address[15:0]};
        res.store_enable = is_write;
      end else if (in_bios) begin
        res.region       = REGION_BIOS;
        res.local_offset = 21'(cmd.address & BIOS_MASK);
      end else begin
        res.region    = REGION_UNMAPPED;
        res.read_zero = !is_write;
      end
      if (is_write) begin
        res.code_clear         = 1'b1;
        res.clear_word_address = cmd.address[31:2];
      end
    end

    res.isolated_now = isolated_next;
  end

endmodule

FILE: sv/console_bus_address_decoder_core.sv
// ============================================================================
// console_bus_address_decoder_core: bus access decoder with cache isolation
// Path: an accepted item goes through the input register, then the result
// register, to res. Throughput: one item per cycle while res_stall is low,
// set by the single decode pass between the two registers; a stall
// on the result side reaches cmd_stall combinationally, in the same cycle.
// Reset: rst clears both valid flags and the isolation flag (writes enabled).
// ============================================================================
module console_bus_address_decoder_core
  import cbad_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  cbad_cmd_t cmd,
  output logic      res_valid,
  input  logic      res_stall,
  output cbad_res_t res
);

  // Input register stage. It holds one accepted item until the result
  // register can take its decoded form.
  logic      in_valid;
  cbad_cmd_t in_cmd;

  // The single piece of architectural state: the cache isolation flag.
  logic      cache_isolated;

  cbad_res_t dec_res;
  logic      iso_next;
  logic      advance;
  logic      take;

  // The result register frees up when it is empty or its item is taken this
  // cycle. The input stage moves forward whenever the result register frees.
  assign advance   = !res_valid || !res_stall;
  assign cmd_stall = in_valid && !advance;
  assign take      = cmd_valid && !cmd_stall;

  cbad_decode u_decode (
    .cmd           (in_cmd),
    .isolated      (cache_isolated),
    .res           (dec_res),
    .isolated_next (iso_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_cmd <= cmd;
    end
  end

  // The isolation flag is committed only when the item that decides it moves
  // into the result register, so items always see the flag in program order.
  always_ff @(posedge clk) begin
    if (rst) begin
      cache_isolated <= 1'b0;
    end else if (in_valid && advance) begin
      cache_isolated <= iso_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && advance) begin
      res <= dec_res;
    end
  end

`ifndef SYNTHESIS
  // An invalidate pulse only comes with entering isolation.
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.icache_invalidate) |-> res.isolated_now)
    else $error("icache invalidate without isolation");

  // Cache control writes never store and never clear code.
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.region == REGION_CACHECTL) |-> (!res.store_enable && !res.code_clear))
    else $error("cache control access stored or cleared code");

  // The isolation flag changes only when an item moves to the result register.
  assert property (@(posedge clk) disable iff (rst)
    (cache_isolated != $past(cache_isolated)) |-> $past(in_valid && advance))
    else $error("isolation flag changed without an item");

  // The published isolation status matches the committed flag of the newest item.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && advance) |=> (res.isolated_now == cache_isolated))
    else $error("isolation status out of step with flag");
`endif

endmodule

FILE: tb/tb_console_bus_address_decoder_core.sv
// ============================================================================
// tb_console_bus_address_decoder_core: self-checking bench for the bus decoder
// Drives a short list of hand-picked bus accesses, then about two thousand
// random ones, into the decoder. It mirrors the decode and the cache isolation
// flag on its own and checks every result item field by field, in order.
// ============================================================================
module tb_console_bus_address_decoder_core;
  import cbad_pkg::*;

  // Run shape.
  localparam int RANDOM_ITEMS = 1950;
  localparam int QUIET_TAIL   = 250;   // last random items run with no idling
  localparam int SEGMENT      = 150;   // idle rates are redrawn this often
  localparam int HOLD_AT      = 500;   // random item that triggers the long hold
  localparam int PAUSE_AT     = 1100;  // random item before which the sender drains
  localparam int LONG_HOLD    = 64;    // cycles the result side refuses items
  localparam int DRAIN_LIMIT  = 2000;  // cycles allowed for the pipe to empty
  localparam int REPORT_MAX   = 10;

  // One line of the directed list. When fixed is set, res is the known answer
  // and is checked as it stands; otherwise the mirrored decode supplies it.
  typedef struct packed {
    logic      fixed;
    cbad_cmd_t acc;
    cbad_res_t res;
  } probe_row_t;

  logic      clk;
  logic      rst;
  logic      cmd_valid;
  logic      cmd_stall;
  cbad_cmd_t cmd;
  logic      res_valid;
  logic      res_stall;
  cbad_res_t res;

  // The known answer travels next to the item it belongs to, so the checker
  // sees both at the same clock edge.
  logic      lit_valid;
  cbad_res_t lit_res;

  cbad_res_t  decode_fifo[$];   // decodes of accepted items, oldest first
  probe_row_t probes[$];
  logic       iso_shadow;       // mirrored cache isolation flag
  int         mismatch_count = 0;
  int         result_count   = 0;

  // Idling control shared by the two sides.
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  bit sink_hold_req = 1'b0;
  bit sink_busy     = 1'b0;

  int          idle_levels [4] = '{0, 10, 25, 50};
  logic [31:0] iso_codes   [4] = '{ISO_ON_A, ISO_ON_B, ISO_OFF_A, ISO_OFF_B};
  logic [15:0] ram_bases   [3] = '{PAGE_RAM_BASE0, PAGE_RAM_BASE1, PAGE_RAM_BASE2};
  logic [15:0] bios_bases  [3] = '{PAGE_BIOS_BASE0, PAGE_BIOS_BASE1, PAGE_BIOS_BASE2};

  // Pages beside the window edges, and offsets around the local
  // scratch limit and the ends of a page.
  logic [15:0] border_pages [16] = '{
    16'h007F, 16'h0080, 16'h807F, 16'h8080, 16'hA07F, 16'hA080, 16'h1EFF, 16'h1F01,
    16'h1F7F, 16'h1F81, 16'h1FBF, 16'h1FC7, 16'h1FC8, 16'h9FC8, 16'hBFBF, 16'hFFFE};
  logic [15:0] border_lows [8] = '{
    16'h0000, 16'h0004, 16'h0130, 16'h0FFC, 16'h0FFF, 16'h1000, 16'hFFFC, 16'hFFFF};

  console_bus_address_decoder_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Backstop: a hung handshake ends the run here.
  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

  function automatic logic in_window(input logic [15:0] pg, input logic [15:0] base,
                                     input logic [15:0] count);
    return (pg >= base) && ((pg - base) < count);
  endfunction

  // Decodes one access the way the block should, and updates the mirrored
  // isolation flag when the access is a cache control write.
  function automatic cbad_res_t decode_access(input cbad_cmd_t a);
    cbad_res_t   r;
    logic [15:0] pg;
    logic        wr;
    r         = '0;
    r.region  = REGION_UNMAPPED;
    pg        = a.address[31:16];
    wr        = (a.command == CMD_WRITE);
    if (pg == PAGE_LOCAL) begin
      // The local page ignores isolation and never asks for a code clear.
      r.region       = (a.address[15:0] < LOCAL_LIMIT) ? REGION_LOCAL : REGION_HWPORT;
      r.local_offset = 21'(a.address[15:0]);
      r.store_enable = wr;
    end else if (wr && a.address == CACHE_CTL_ADDR) begin
      r.region       = REGION_CACHECTL;
      r.local_offset = CACHE_CTL_OFFSET;
      if ((a.write_data == ISO_ON_A || a.write_data == ISO_ON_B) && !iso_shadow) begin
        iso_shadow          = 1'b1;
        r.icache_invalidate = 1'b1;
      end else if ((a.write_data == ISO_OFF_A || a.write_data == ISO_OFF_B) && iso_shadow) begin
        iso_shadow = 1'b0;
      end
    end else begin
      if (in_window(pg, PAGE_RAM_BASE0, PAGE_RAM_COUNT) ||
          in_window(pg, PAGE_RAM_BASE1, PAGE_RAM_COUNT) ||
          in_window(pg, PAGE_RAM_BASE2, PAGE_RAM_COUNT)) begin
        r.region       = REGION_WORK;
        r.local_offset = 21'(a.address & RAM_MASK);
        r.store_enable = wr && !iso_shadow;
      end else if (pg == PAGE_PARALLEL) begin
        r.region       = REGION_PARALLEL;
        r.local_offset = 21'(a.address[15:0]);
        r.store_enable = wr;
      end else if (in_window(pg, PAGE_BIOS_BASE0, PAGE_BIOS_COUNT) ||
                   in_window(pg, PAGE_BIOS_BASE1, PAGE_BIOS_COUNT) ||
                   in_window(pg, PAGE_BIOS_BASE2, PAGE_BIOS_COUNT)) begin
        // BIOS is read-only: a write is dropped but still clears code.
        r.region       = REGION_BIOS;
        r.local_offset = 21'(a.address & BIOS_MASK);
      end else begin
        r.read_zero = !wr;
      end
      if (wr) begin
        r.code_clear         = 1'b1;
        r.clear_word_address = a.address[31:2];
      end
    end
    r.isolated_now = iso_shadow;
    return r;
  endfunction

  task automatic show_result(input string tag, input cbad_res_t r);
    $display("  %s: region %0d offset %h store %b zero %b inval %b clear %b word %h iso %b",
             tag, r.region, r.local_offset, r.store_enable, r.read_zero,
             r.icache_invalidate, r.code_clear, r.clear_word_address, r.isolated_now);
  endtask

  // Checker. All signals are read at the rising edge, before anything driven
  // at that edge lands, so the order of processes inside a step is irrelevant.
  // The result side is checked first; an item accepted at the same edge cannot
  // have produced it.
  always @(posedge clk) begin : scoreboard
    cbad_res_t want;
    cbad_res_t decoded;
    if (rst) begin
      iso_shadow = 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        result_count++;
        if (decode_fifo.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("result item %0d at %0t arrived with nothing outstanding",
                     result_count, $time);
            show_result("got ", res);
          end
        end else begin
          want = decode_fifo.pop_front();
          if (res.region !== want.region || res.local_offset !== want.local_offset ||
              res.store_enable !== want.store_enable || res.read_zero !== want.read_zero ||
              res.icache_invalidate !== want.icache_invalidate ||
              res.code_clear !== want.code_clear ||
              res.clear_word_address !== want.clear_word_address ||
              res.isolated_now !== want.isolated_now) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX) begin
              $display("result item %0d at %0t differs", result_count, $time);
              show_result("want", want);
              show_result("got ", res);
            end
          end
        end
      end
      if (cmd_valid && !cmd_stall) begin
        // Always run the decode so the isolation mirror stays in step, even
        // when a known answer overrides it.
        decoded = decode_access(cmd);
        decode_fifo.push_back(lit_valid ? lit_res : decoded);
      end
    end
  end

  // Result side. Refuses items in random bursts, and once, on request, for
  // a long hold so that the block backs up and stalls its input while the
  // sender keeps offering items.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        sink_busy     = 1'b1;
        stall_left    = LONG_HOLD;
      end else if (stall_left == 0 && sink_idle_pct != 0 &&
                   $urandom_range(0, 99) < sink_idle_pct) begin
        stall_left = $urandom_range(1, 4);
      end
      if (stall_left > 0) begin
        res_stall <= 1'b1;
        stall_left--;
      end else begin
        res_stall <= 1'b0;
        sink_busy  = 1'b0;
      end
    end
  end

  // Offers one item and returns at the edge that takes it. Valid stays high,
  // so a following call simply replaces the payload in the same step.
  task automatic push_cmd(input cbad_cmd_t c, input logic fixed, input cbad_res_t r);
    cmd_valid <= 1'b1;
    cmd       <= c;
    lit_valid <= fixed;
    lit_res   <= r;
    do @(posedge clk); while (cmd_stall !== 1'b0);
  endtask

  task automatic idle_cmd(input int cycles);
    cmd_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stops offering items and waits until every outstanding result has come.
  // The first edge lets the checker log the item taken at the previous one.
  task automatic drain_results();
    int waited;
    waited = 0;
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (decode_fifo.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  initial begin : stimulus
    cbad_cmd_t   c;
    logic [15:0] pg;
    logic [15:0] lo;
    int          kind;

    rst       <= 1'b1;
    cmd_valid <= 1'b0;
    cmd       <= '0;
    lit_valid <= 1'b0;
    lit_res   <= '0;

    // Directed accesses. The known answers cover the state after reset, the
    // address extremes, the unmapped read of the cache control address and
    // entry into isolation; the rest go through the mirrored decode.
    probes.push_back('{1'b1, '{CMD_READ, 32'h0000_0000, 32'h0000_0000},
                       '{REGION_WORK, 21'h0, 1'b0, 1'b0, 1'b0, 1'b0, 30'h0, 1'b0}});
    probes.push_back('{1'b1, '{CMD_WRITE, 32'h0000_0000, 32'hFFFF_FFFF},
                       '{REGION_WORK, 21'h0, 1'b1, 1'b0, 1'b0, 1'b1, 30'h0, 1'b0}});
    probes.push_back('{1'b1, '{CMD_READ, 32'hFFFF_FFFF, 32'h0000_0000},
                       '{REGION_UNMAPPED, 21'h0, 1'b0, 1'b1, 1'b0, 1'b0, 30'h0, 1'b0}});
    probes.push_back('{1'b1, '{CMD_WRITE, 32'hFFFF_FFFF, 32'h0000_0000},
                       '{REGION_UNMAPPED, 21'h0, 1'b0, 1'b0, 1'b0, 1'b1, 30'h3FFF_FFFF, 1'b0}});
    // Top of work RAM, the page just past it, and two mirrors.
    probes.push_back('{1'b0, '{CMD_READ,  32'h007F_FFFC, 32'h0}, '0});
    probes.push_back('{1'b0, '{CMD_WRITE, 32'h0080_0000, 32'h1234_5678}, '0});
    probes.push_back('{1'b0, '{CMD_WRITE, 32'h8012_3454, 32'hA5A5_A5A5}, '0});
    probes.push_back('{1'b0, '{CMD_READ,  32'hA07F_FFFF, 32'h0}, '0});
    // Parallel port, local scratch, hardware register port.
    probes.push_back('{1'b0, '{CMD_READ,  32'h1F00_0010, 32'h0}, '0});
    probes.push_back('{1'b0, '{CMD_WRITE, 32'h1F00_FFFC, 32'h5A5A_5A5A}, '0});
    probes.push_back('{1'b0, '{CMD_READ,  32'h1F80_0FFC, 32'h0}, '0});
    probes.push_back('{1'b0, '{CMD_WRITE, 32'h1F80_1000, 32'h0000_FFFF}, '0});
    // BIOS reads and a dropped BIOS write, then the page just past BIOS.
    probes.push_back('{1'b0, '{CMD_READ,  32'h1FC7_FFFC, 32'h0}, '0});
    probes.push_back('{1'b0, '{CMD_WRITE, 32'hBFC0_0000, 32'h0BAD_F00D}, '0});
    probes.push_back('{1'b0, '{CMD_READ,  32'h9FC1_2344, 32'h0}, '0});
    probes.push_back('{1'b0, '{CMD_READ,  32'h1FC8_0000, 32'h0}, '0});
    // Cache control: a read is unmapped, other data changes nothing.
    probes.push_back('{1'b1, '{CMD_READ, CACHE_CTL_ADDR, 32'h0},
                       '{REGION_UNMAPPED, 21'h0, 1'b0, 1'b1, 1'b0, 1'b0, 30'h0, 1'b0}});
    probes.push_back('{1'b0, '{CMD_WRITE, CACHE_CTL_ADDR, 32'h1234_5678}, '0});
    probes.push_back('{1'b1, '{CMD_WRITE, CACHE_CTL_ADDR, ISO_ON_A},
                       '{REGION_CACHECTL, CACHE_CTL_OFFSET, 1'b0, 1'b0, 1'b1, 1'b0, 30'h0,
                         1'b1}});
    // Isolated: a repeated request is a no-op, RAM writes drop, local stores.
    probes.push_back('{1'b0, '{CMD_WRITE, CACHE_CTL_ADDR, ISO_ON_B}, '0});
    probes.push_back('{1'b0, '{CMD_WRITE, 32'h0000_1000, 32'h0000_0005}, '0});
    probes.push_back('{1'b0, '{CMD_WRITE, 32'h1F80_0000, 32'h0000_0007}, '0});
    // Release, then a full cycle with the other codes.
    probes.push_back('{1'b0, '{CMD_WRITE, CACHE_CTL_ADDR, ISO_OFF_B}, '0});
    probes.push_back('{1'b0, '{CMD_WRITE, CACHE_CTL_ADDR, ISO_ON_B}, '0});
    probes.push_back('{1'b0, '{CMD_WRITE, CACHE_CTL_ADDR, ISO_OFF_A}, '0});

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (probes[i]) begin
      push_cmd(probes[i].acc, probes[i].fixed, probes[i].res);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Idle rates change per segment, so the run has stretches with heavy,
      // light and no idling on either side; the tail has none at all.
      if (n >= RANDOM_ITEMS - QUIET_TAIL) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end else if (n % SEGMENT == 0) begin
        src_idle_pct  = idle_levels[$urandom_range(0, 3)];
        sink_idle_pct = idle_levels[$urandom_range(0, 3)];
      end
      if (n == HOLD_AT) begin
        sink_hold_req = 1'b1;
      end
      if (n == PAUSE_AT) begin
        drain_results();
      end
      // The sender never pauses during the long hold, so the block fills up.
      if (!sink_busy && src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
        idle_cmd($urandom_range(1, 4));
      end

      // Half the items aim at a mapped window or one of its edges; cache control
      // writes are frequent so that isolation toggles often.
      kind         = $urandom_range(0, 11);
      c.command    = 1'($urandom_range(0, 1));
      c.write_data = $urandom;
      if ($urandom_range(0, 7) == 0) begin
        c.write_data = iso_codes[$urandom_range(0, 3)];
      end
      lo = 16'($urandom);
      case (kind) inside
        [0:1]: pg = ram_bases[$urandom_range(0, 2)] + 16'($urandom_range(0, 'h7F));
        2: begin
          pg = PAGE_LOCAL;
          if ($urandom_range(0, 1) == 1) begin
            lo = 16'($urandom_range(0, 'hFFF));
          end
        end
        3: pg = PAGE_PARALLEL;
        4: pg = bios_bases[$urandom_range(0, 2)] + 16'($urandom_range(0, 7));
        [5:6]: begin
          {pg, lo}  = CACHE_CTL_ADDR;
          c.command = ($urandom_range(0, 3) != 0) ? CMD_WRITE : CMD_READ;
          if ($urandom_range(0, 3) != 0) begin
            c.write_data = iso_codes[$urandom_range(0, 3)];
          end
        end
        7: begin
          pg = border_pages[$urandom_range(0, 15)];
          if ($urandom_range(0, 1) == 1) begin
            lo = border_lows[$urandom_range(0, 7)];
          end
        end
        // One bit away from the cache control address.
        8: {pg, lo} = CACHE_CTL_ADDR ^ (32'd1 << $urandom_range(0, 31));
        default: {pg, lo} = $urandom;
      endcase
      c.address = {pg, lo};
      push_cmd(c, 1'b0, '0);
    end

    drain_results();
    // Wait on, to catch any result the block should not produce.
    repeat (8) @(posedge clk);
    if (decode_fifo.size() != 0) begin
      $display("%0d result items never arrived", decode_fifo.size());
      mismatch_count += decode_fifo.size();
    end
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: console_bus_address_decoder_core.f
sv/cbad_pkg.sv
sv/cbad_decode.sv
sv/console_bus_address_decoder_core.sv
tb/tb_console_bus_address_decoder_core.sv
